// File: rtl/rrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and codes for the round-robin scheduler block.
// ----------------------------------------------------------------------------
package rrs_pkg;

   // command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;

   // status codes
   localparam logic [2:0] ST_CLEARED = 3'd0;
   localparam logic [2:0] ST_LOADED  = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_SLICE   = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;

   // shared arithmetic unit operations
   typedef enum logic {
      ALU_ADD_SAT = 1'b0,
      ALU_SUB     = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] arrival_time;
      logic [15:0] burst_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  process_index;
      logic [31:0] slice_end_time;
      logic        finished;
      logic [31:0] waiting_time;
      logic [31:0] turnaround_time;
   } rsp_type;

endpackage

// File: rtl/rrs_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrs_alu
// Shared 32-bit adder: saturating add, or subtract with a greater-or-equal flag.
// ----------------------------------------------------------------------------
module rrs_alu (
   input  rrs_pkg::alu_op_type op,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   output logic [31:0]         result,
   output logic                ge
);
   logic [32:0] sum;

   // one carry chain for both operations
   always_comb begin
      if (op == rrs_pkg::ALU_ADD_SAT) begin
         sum = {1'b0, a} + {1'b0, b};
         result = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else begin
         sum = {1'b0, a} + {1'b0, ~b} + 33'd1;
         result = sum[31:0];
      end
      ge = sum[32];
   end

endmodule

// File: rtl/round_robin_cpu_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_cpu_scheduler_top
// Round-robin process scheduler with a time quantum and a sorted process table.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result shows
// on rsp_data for a single cycle with rsp_valid, and the receiver cannot stall
// it. A clear answers in the next cycle. A load walks the table one entry a
// cycle to insert in arrival order, then fixes the ready queue one entry a
// cycle; a load into a full table answers with ST_FULL. A slice walks to the
// first unfinished entry, rescans the table for arrivals when the queue is
// empty, runs the queue head, then rescans the whole table for arrivals, one
// entry a cycle through a single shared 32-bit adder.
// The quantum register may be written while busy is low.
// ----------------------------------------------------------------------------
module round_robin_cpu_scheduler_top #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rrs_pkg::req_type req_data,
   output logic             rsp_valid,
   output rrs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   localparam int IW = $clog2(MAX_PROCESSES);
   localparam int CW = $clog2(MAX_PROCESSES + 1);
   localparam logic [CW-1:0] P_C = CW'(MAX_PROCESSES);

   typedef enum logic [3:0] {
      S_IDLE, S_LD_SHIFT, S_LD_FIX, S_FIND, S_SCAN, S_POP, S_EXEC, S_TURN, S_WAIT
   } state_type;

   typedef enum logic [1:0] {
      SCAN_PRE, SCAN_FIN, SCAN_PUSH
   } scan_type;

   state_type        state_ff;
   scan_type         scan_mode_ff;
   logic [15:0]      tq_ff;
   logic [15:0]      arrival_ff [MAX_PROCESSES];
   logic [15:0]      burst_ff [MAX_PROCESSES];
   logic [15:0]      remain_ff [MAX_PROCESSES];
   logic [IW-1:0]    lidx_ff [MAX_PROCESSES];
   logic [IW-1:0]    fifo_ff [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] done_ff;
   logic [MAX_PROCESSES-1:0] queued_ff;
   logic [IW-1:0]    head_ff;
   logic [CW-1:0]    fcount_ff;
   logic [CW-1:0]    pcount_ff;
   logic [31:0]      time_ff;
   logic             started_ff;
   logic [CW-1:0]    k_ff;
   logic [CW-1:0]    pos_ff;
   logic [IW-1:0]    cur_ff;
   logic [15:0]      arr_in_ff;
   logic [15:0]      bur_in_ff;
   logic [31:0]      tt_ff;
   logic             rsp_valid_ff;
   rrs_pkg::rsp_type rsp_ff;

   logic [IW-1:0]    k_idx;
   logic [IW-1:0]    km1_idx;
   logic [CW:0]      fix_sum;
   logic [IW-1:0]    fix_slot;
   logic [CW:0]      push_sum;
   logic [IW-1:0]    push_slot;
   logic [15:0]      tq_eff;
   rrs_pkg::alu_op_type alu_op;
   logic [31:0]      alu_a;
   logic [31:0]      alu_b;
   logic [31:0]      alu_y;
   logic             alu_ge;

   assign k_idx   = k_ff[IW-1:0];
   assign km1_idx = IW'(k_ff - CW'(1));
   assign tq_eff  = (tq_ff == 16'd0) ? 16'd1 : tq_ff;

   // ring slot arithmetic for queue walk and push
   always_comb begin
      fix_sum  = {1'b0, CW'(head_ff)} + {1'b0, k_ff};
      push_sum = {1'b0, CW'(head_ff)} + {1'b0, fcount_ff};
      fix_slot  = (fix_sum >= (CW+1)'(MAX_PROCESSES)) ?
                  IW'(fix_sum - (CW+1)'(MAX_PROCESSES)) : IW'(fix_sum);
      push_slot = (push_sum >= (CW+1)'(MAX_PROCESSES)) ?
                  IW'(push_sum - (CW+1)'(MAX_PROCESSES)) : IW'(push_sum);
   end

   // operand select for the shared adder
   always_comb begin
      alu_op = rrs_pkg::ALU_SUB;
      alu_a  = time_ff;
      alu_b  = 32'd0;
      case (state_ff)
         S_LD_SHIFT: begin
            alu_a = {16'd0, arr_in_ff};
            alu_b = {16'd0, arrival_ff[km1_idx]};
         end
         S_FIND, S_SCAN: alu_b = {16'd0, arrival_ff[k_idx]};
         S_EXEC: begin
            alu_op = rrs_pkg::ALU_ADD_SAT;
            alu_b  = (remain_ff[cur_ff] <= tq_eff) ? {16'd0, remain_ff[cur_ff]}
                                                   : {16'd0, tq_eff};
         end
         S_TURN: alu_b = {16'd0, arrival_ff[cur_ff]};
         S_WAIT: begin
            alu_a = tt_ff;
            alu_b = {16'd0, burst_ff[cur_ff]};
         end
         default: alu_b = 32'd0;
      endcase
   end

   rrs_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_y),
      .ge     (alu_ge)
   );

   // sequencer, tables and result register
   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (csr_valid) begin
         tq_ff <= csr_data;
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               arr_in_ff <= req_data.arrival_time;
               bur_in_ff <= req_data.burst_time;
               rsp_ff    <= '0;
               k_ff      <= '0;
               if (req_data.command == rrs_pkg::CMD_CLEAR) begin
                  done_ff      <= '0;
                  queued_ff    <= '0;
                  head_ff      <= '0;
                  fcount_ff    <= '0;
                  pcount_ff    <= '0;
                  time_ff      <= '0;
                  started_ff   <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else if (req_data.command == rrs_pkg::CMD_LOAD) begin
                  if (pcount_ff >= P_C) begin
                     rsp_ff.status <= rrs_pkg::ST_FULL;
                     rsp_valid_ff  <= 1'b1;
                  end else begin
                     k_ff     <= pcount_ff;
                     state_ff <= S_LD_SHIFT;
                  end
               end else begin
                  state_ff <= S_FIND;
               end
            end
         end
         // insertion walk from the tail, one entry a beat
         S_LD_SHIFT: begin
            if (k_ff != '0 && !alu_ge) begin
               arrival_ff[k_idx] <= arrival_ff[km1_idx];
               burst_ff[k_idx]   <= burst_ff[km1_idx];
               remain_ff[k_idx]  <= remain_ff[km1_idx];
               lidx_ff[k_idx]    <= lidx_ff[km1_idx];
               done_ff[k_idx]    <= done_ff[km1_idx];
               queued_ff[k_idx]  <= queued_ff[km1_idx];
               k_ff <= k_ff - CW'(1);
            end else begin
               arrival_ff[k_idx] <= arr_in_ff;
               burst_ff[k_idx]   <= bur_in_ff;
               remain_ff[k_idx]  <= bur_in_ff;
               lidx_ff[k_idx]    <= IW'(pcount_ff);
               done_ff[k_idx]    <= 1'b0;
               queued_ff[k_idx]  <= 1'b0;
               pos_ff   <= k_ff;
               k_ff     <= '0;
               state_ff <= S_LD_FIX;
            end
         end
         // renumber queued entries behind the insertion point
         S_LD_FIX: begin
            if (k_ff == fcount_ff) begin
               rsp_ff.status        <= rrs_pkg::ST_LOADED;
               rsp_ff.process_index <= 4'(pcount_ff);
               rsp_valid_ff         <= 1'b1;
               pcount_ff            <= pcount_ff + CW'(1);
               state_ff             <= S_IDLE;
            end else begin
               if (CW'(fifo_ff[fix_slot]) >= pos_ff) begin
                  fifo_ff[fix_slot] <= fifo_ff[fix_slot] + IW'(1);
               end
               k_ff <= k_ff + CW'(1);
            end
         end
         // first unfinished entry, start time and idle jump
         S_FIND: begin
            if (k_ff == pcount_ff) begin
               rsp_ff.status         <= rrs_pkg::ST_EMPTY;
               rsp_ff.slice_end_time <= time_ff;
               rsp_valid_ff          <= 1'b1;
               state_ff              <= S_IDLE;
            end else if (!done_ff[k_idx]) begin
               if (!started_ff) begin
                  started_ff <= 1'b1;
                  time_ff    <= {16'd0, arrival_ff[k_idx]};
               end else if (fcount_ff == '0 && !alu_ge) begin
                  time_ff <= {16'd0, arrival_ff[k_idx]};
               end
               k_ff         <= '0;
               scan_mode_ff <= SCAN_PRE;
               state_ff     <= (fcount_ff == '0) ? S_SCAN : S_POP;
            end else begin
               k_ff <= k_ff + CW'(1);
            end
         end
         // arrival scan, one entry a beat
         S_SCAN: begin
            if (k_ff == pcount_ff) begin
               case (scan_mode_ff)
                  SCAN_PRE: state_ff <= S_POP;
                  SCAN_PUSH: begin
                     if (fcount_ff < P_C) begin
                        fifo_ff[push_slot] <= cur_ff;
                        fcount_ff          <= fcount_ff + CW'(1);
                        queued_ff[cur_ff]  <= 1'b1;
                     end
                     rsp_ff.slice_end_time <= time_ff;
                     rsp_valid_ff          <= 1'b1;
                     state_ff              <= S_IDLE;
                  end
                  default: begin
                     rsp_ff.slice_end_time <= time_ff;
                     rsp_valid_ff          <= 1'b1;
                     state_ff              <= S_IDLE;
                  end
               endcase
            end else begin
               if (!(scan_mode_ff == SCAN_PUSH && k_idx == cur_ff) &&
                   !done_ff[k_idx] && !queued_ff[k_idx] && alu_ge &&
                   fcount_ff < P_C) begin
                  fifo_ff[push_slot] <= k_idx;
                  fcount_ff          <= fcount_ff + CW'(1);
                  queued_ff[k_idx]   <= 1'b1;
               end
               k_ff <= k_ff + CW'(1);
            end
         end
         // take the queue head
         S_POP: begin
            if (fcount_ff == '0) begin
               rsp_ff.status         <= rrs_pkg::ST_EMPTY;
               rsp_ff.slice_end_time <= time_ff;
               rsp_valid_ff          <= 1'b1;
               state_ff              <= S_IDLE;
            end else begin
               cur_ff                     <= fifo_ff[head_ff];
               queued_ff[fifo_ff[head_ff]] <= 1'b0;
               head_ff   <= (head_ff == IW'(MAX_PROCESSES - 1)) ? '0 : head_ff + IW'(1);
               fcount_ff <= fcount_ff - CW'(1);
               rsp_ff.status        <= rrs_pkg::ST_SLICE;
               rsp_ff.process_index <= 4'(lidx_ff[fifo_ff[head_ff]]);
               state_ff  <= S_EXEC;
            end
         end
         // run for the remaining work or one quantum
         S_EXEC: begin
            time_ff <= alu_y;
            k_ff    <= '0;
            if (remain_ff[cur_ff] <= tq_eff) begin
               remain_ff[cur_ff] <= '0;
               done_ff[cur_ff]   <= 1'b1;
               rsp_ff.finished   <= 1'b1;
               state_ff          <= S_TURN;
            end else begin
               remain_ff[cur_ff] <= remain_ff[cur_ff] - tq_eff;
               scan_mode_ff      <= SCAN_PUSH;
               state_ff          <= S_SCAN;
            end
         end
         S_TURN: begin
            tt_ff                  <= alu_y;
            rsp_ff.turnaround_time <= alu_y;
            state_ff               <= S_WAIT;
         end
         S_WAIT: begin
            rsp_ff.waiting_time <= alu_ge ? alu_y : 32'd0;
            scan_mode_ff        <= SCAN_FIN;
            state_ff            <= S_SCAN;
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_mode_ff <= SCAN_PRE;
         tq_ff        <= 16'd4;
         done_ff      <= '0;
         queued_ff    <= '0;
         head_ff      <= '0;
         fcount_ff    <= '0;
         pcount_ff    <= '0;
         time_ff      <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // queue never holds more than the table
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= pcount_ff)
      else $error("ready queue larger than table");

   // table never overflows
   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= P_C)
      else $error("process count above capacity");

   // an accepted command either answers next cycle or keeps the block busy
   a_cmd_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("command dropped");
`endif

endmodule
